// ===== hw/rtl/bgtp_pkg.sv =====
package bgtp_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
	localparam int TIME_BITS  = 32;

	// Divide-by-three unit: the dividend 2*burst+old is below 3*2^TIME_BITS.
	localparam int DIV_W      = TIME_BITS + 2;
	localparam int DIV_RADIX  = 4;
	localparam int DIV_STEPS  = (DIV_W + DIV_RADIX - 1) / DIV_RADIX;
	localparam int DIV_PAD_W  = DIV_STEPS * DIV_RADIX;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] FN_TICK   = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_REMOVE = 2'd2;

	typedef struct packed {
		logic                 valid;
		logic [TIME_BITS-1:0] e;
		logic [TIME_BITS-1:0] q;
	} entry_t;

	typedef struct packed {
		logic   en;
		entry_t d;
	} cell_wr_t;

endpackage

// ===== hw/rtl/burst_goodness_task_picker.sv =====
// Channel  Handshake           Word
// in       in_valid/in_stall   func, slot, now
// out      out_valid/out_stall running_slot, switched, bad_request
//
// Insert, remove, a bad request and a tick with only the seed task are answered
// in the cycle after they are accepted. A tick with more tasks runs the
// divide-by-three unit, then ST_SCAN_A to ST_SCAN_C per slot as the row of
// cells rotates past the shared cross-multiply compare, then ST_FINISH.
// Reset makes slot 0 the running task. A new word is taken at the edge where
// the prior result leaves the output register, not while stalled or busy.
module burst_goodness_task_picker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  slot,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  running_slot,
	output logic        switched,
	output logic        bad_request
);
	import bgtp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_SCAN_A, ST_SCAN_B, ST_SCAN_C, ST_FINISH
	} state_t;

	state_t                 state_q;
	entry_t                 cells [TASK_SLOTS];
	cell_wr_t               wr [TASK_SLOTS];
	logic                   shift;

	logic [SLOT_W-1:0]      run_q;
	logic [CNT_W-1:0]       count_q;
	logic [TIME_BITS-1:0]   cpu_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [TIME_BITS-1:0]   ne_q;
	logic [SLOT_W-1:0]      idx_q;
	logic                   have_q;
	logic [SLOT_W-1:0]      best_q;
	logic [TIME_BITS:0]     be_q;
	logic [TIME_BITS:0]     bw_q;

	logic [TIME_BITS:0]     e1_s1;
	logic [TIME_BITS:0]     w1_s1;
	logic                   elig_s1;
	logic [SLOT_W-1:0]      idx_s1;
	logic [2*TIME_BITS+1:0] p1_s2;
	logic [2*TIME_BITS+1:0] p2_s2;

	logic                   out_valid_q;
	logic [3:0]             run_out_q;
	logic                   sw_q;
	logic                   bad_q;

	logic                   accept;
	logic [TIME_BITS-1:0]   now_t;
	logic [SLOT_W-1:0]      sidx;
	logic                   slot_ok;
	logic                   slot_valid;
	entry_t                 run_ent;
	entry_t                 slot_ent;
	logic                   ins_ok;
	logic                   rem_ok;
	logic                   do_switch;
	logic                   div_start;
	logic [DIV_W-1:0]       dividend;
	logic                   div_done;
	logic [TIME_BITS-1:0]   quotient;
	logic [TIME_BITS-1:0]   burst;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign now_t      = now[TIME_BITS-1:0];
	assign sidx       = SLOT_W'(slot);
	assign slot_ok    = 32'(slot) < TASK_SLOTS;
	assign run_ent    = cells[run_q];
	assign slot_ent   = cells[sidx];
	// The seed task in slot 0 is always valid.
	assign slot_valid = (sidx == '0) || slot_ent.valid;
	assign ins_ok     = slot_ok && !slot_valid;
	assign rem_ok     = slot_ok && (sidx != '0) && slot_valid;
	assign do_switch  = have_q && (best_q != run_q);
	assign burst      = now_t - cpu_q;
	assign dividend   = {burst, 1'b0} + DIV_W'(run_ent.e);
	assign div_start  = accept && (func == FN_TICK) && (count_q > CNT_W'(1));
	assign shift      = (state_q == ST_SCAN_A);

	bgtp_div3 u_div3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.done_q   (div_done),
		.quotient (quotient)
	);

	for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
		bgtp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.nb_in  (cells[(i + 1) % TASK_SLOTS]),
			.wr     (wr[i]),
			.ent_q  (cells[i])
		);
	end

	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			wr[i] = '0;
			if (accept && func == FN_INSERT && ins_ok && sidx == SLOT_W'(i)) begin
				wr[i].en = 1'b1;
				wr[i].d  = '{valid: 1'b1, e: '0, q: now_t};
			end else if (accept && func == FN_REMOVE && rem_ok
					&& sidx == SLOT_W'(i)) begin
				wr[i].en       = 1'b1;
				wr[i].d        = cells[i];
				wr[i].d.valid  = 1'b0;
			end else if (state_q == ST_FINISH && do_switch && run_q == SLOT_W'(i)) begin
				wr[i].en = 1'b1;
				wr[i].d  = '{valid: cells[i].valid, e: ne_q, q: now_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= '0;
			count_q     <= CNT_W'(1);
			cpu_q       <= '0;
			have_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			run_out_q   <= '0;
			sw_q        <= 1'b0;
			bad_q       <= 1'b0;
		end else begin
			// A word accepted in the same cycle decides the valid flag below.
			if (out_valid_q && !out_stall && !accept) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FN_TICK: begin
								if (count_q > CNT_W'(1)) begin
									now_q       <= now_t;
									out_valid_q <= 1'b0;
									state_q     <= ST_DIV;
								end else begin
									run_q       <= '0;
									run_out_q   <= '0;
									sw_q        <= 1'b0;
									bad_q       <= 1'b0;
									out_valid_q <= 1'b1;
								end
							end
							FN_INSERT: begin
								if (ins_ok) begin
									count_q <= count_q + 1'b1;
								end
								run_out_q   <= 4'(run_q);
								sw_q        <= 1'b0;
								bad_q       <= !ins_ok;
								out_valid_q <= 1'b1;
							end
							FN_REMOVE: begin
								if (rem_ok) begin
									count_q <= count_q - 1'b1;
									if (run_q == sidx) begin
										run_q     <= '0;
										run_out_q <= '0;
										cpu_q     <= now_t;
									end else begin
										run_out_q <= 4'(run_q);
									end
								end else begin
									run_out_q <= 4'(run_q);
								end
								sw_q        <= 1'b0;
								bad_q       <= !rem_ok;
								out_valid_q <= 1'b1;
							end
							default: begin
								run_out_q   <= 4'(run_q);
								sw_q        <= 1'b0;
								bad_q       <= 1'b1;
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						ne_q    <= quotient;
						idx_q   <= '0;
						have_q  <= 1'b0;
						state_q <= ST_SCAN_A;
					end
				end
				ST_SCAN_A: begin
					// Cell 0 holds slot idx_q; the running task is judged on its
					// fresh estimate with no wait.
					elig_s1 <= cells[0].valid && (idx_q != '0);
					idx_s1  <= idx_q;
					if (idx_q == run_q) begin
						e1_s1 <= {1'b0, ne_q} + 1'b1;
						w1_s1 <= (TIME_BITS + 1)'(1);
					end else begin
						e1_s1 <= {1'b0, cells[0].e} + 1'b1;
						w1_s1 <= {1'b0, now_q - cells[0].q} + 1'b1;
					end
					state_q <= ST_SCAN_B;
				end
				ST_SCAN_B: begin
					p1_s2   <= e1_s1 * bw_q;
					p2_s2   <= be_q * w1_s1;
					state_q <= ST_SCAN_C;
				end
				ST_SCAN_C: begin
					// Strict less keeps the lowest slot on a tie.
					if (elig_s1 && (!have_q || p1_s2 < p2_s2)) begin
						have_q <= 1'b1;
						best_q <= idx_s1;
						be_q   <= e1_s1;
						bw_q   <= w1_s1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == SLOT_W'(TASK_SLOTS - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN_A;
					end
				end
				ST_FINISH: begin
					if (do_switch) begin
						cpu_q     <= now_q;
						run_q     <= best_q;
						run_out_q <= 4'(best_q);
						sw_q      <= 1'b1;
					end else begin
						run_out_q <= 4'(run_q);
						sw_q      <= 1'b0;
					end
					bad_q       <= 1'b0;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign running_slot = run_out_q;
	assign switched     = sw_q;
	assign bad_request  = bad_q;

endmodule

// ===== hw/rtl/bgtp_cell.sv =====
module bgtp_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  bgtp_pkg::entry_t  nb_in,
	input  bgtp_pkg::cell_wr_t wr,
	output bgtp_pkg::entry_t  ent_q
);
	import bgtp_pkg::*;

	// During a scan the row rotates one place per shift; a full lap brings
	// every entry back to its home cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (shift) begin
			ent_q <= nb_in;
		end else if (wr.en) begin
			ent_q <= wr.d;
		end
	end

endmodule

// ===== hw/rtl/bgtp_div3.sv =====
module bgtp_div3 (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [bgtp_pkg::DIV_W-1:0]            dividend,
	output logic                                  done_q,
	output logic [bgtp_pkg::TIME_BITS-1:0]        quotient
);
	import bgtp_pkg::*;

	logic [1:0]             rem_q;
	logic [DIV_PAD_W-1:0]   sh_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [1:0]             rem_nx;
	logic [DIV_PAD_W-1:0]   sh_nx;

	// Long division by three, DIV_RADIX quotient bits per cycle. Quotient
	// bits shift in from the right as dividend bits leave on the left.
	always_comb begin
		logic [2:0] t;
		logic       qb;
		rem_nx = rem_q;
		sh_nx  = sh_q;
		for (int k = 0; k < DIV_RADIX; k++) begin
			t = {rem_nx, sh_nx[DIV_PAD_W-1]};
			if (t >= 3'd3) begin
				t  = t - 3'd3;
				qb = 1'b1;
			end else begin
				qb = 1'b0;
			end
			rem_nx = t[1:0];
			sh_nx  = {sh_nx[DIV_PAD_W-2:0], qb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			sh_q   <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			sh_q   <= DIV_PAD_W'(dividend);
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			rem_q  <= rem_nx;
			sh_q   <= sh_nx;
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quotient = sh_q[TIME_BITS-1:0];

endmodule
